// File: rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int PosW        = 12;
  localparam int CfgW        = 13;
  localparam int BitsPerWord = 8;
  localparam int OffW        = 3;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_RANGE     = 2'd1,
    RC_NOT_FOUND = 2'd2
  } res_code_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_WR,
    S_CHK,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic            req_type;
    logic [PosW-1:0] position;
    logic            bit_value;
  } req_t;

  typedef struct packed {
    res_code_e       code;
    logic [PosW-1:0] index;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/block_bitmap_allocator_core.sv
// Occupancy bitmap of MAX_BITS bits held in a MAX_BITS/8 x 8 RAM, with set and
// find-first requests. After reset a clearing pass writes one word per cycle,
// and no request is taken meanwhile; configuration writes are taken at any
// time. One request is worked at a time. A set goes through read, write and
// finish from acceptance to result valid, a request whose position is at or
// past the limit goes straight to finish, and a find scans the RAM word by
// word before it finishes, since the scan compares one stored word per cycle
// on the single RAM read port. The result sits in an output register, so a
// new request is taken while the previous result waits.

`default_nettype none

module block_bitmap_allocator_core #(
  parameter int MAX_BITS = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [bba_pkg::CfgW-1:0] cfg_bits_in_use_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    req_type_i,
  input  wire logic [bba_pkg::PosW-1:0] position_i,
  input  wire logic                    bit_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   result_code_o,
  output logic [bba_pkg::PosW-1:0]     found_index_o
);

  import bba_pkg::*;

  localparam int LimBits = $clog2(MAX_BITS + 1) + 1;
  localparam int LimW    = (LimBits > CfgW) ? LimBits : CfgW;

  logic [CfgW-1:0] bits_in_use_q;
  logic [LimW-1:0] cfg_ext;
  logic [LimW-1:0] limit;
  req_t            req;
  res_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= 13'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bits_in_use_q <= cfg_bits_in_use_i;
    end
  end

  // saturate the limit at capacity
  assign cfg_ext = LimW'(bits_in_use_q);
  assign limit   = (cfg_ext > LimW'(MAX_BITS)) ? LimW'(MAX_BITS) : cfg_ext;

  assign req.req_type  = req_type_i;
  assign req.position  = position_i;
  assign req.bit_value = bit_value_i;

  bba_ctrl #(
    .MAX_BITS(MAX_BITS),
    .LIM_W   (LimW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign result_code_o = res.code;
  assign found_index_o = res.index;

endmodule

`default_nettype wire

// File: rtl/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl #(
  parameter int MAX_BITS = 4096,
  parameter int LIM_W    = 13
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [LIM_W-1:0]  limit_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bba_pkg::req_t     req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bba_pkg::res_t          res_o
);

  import bba_pkg::*;

  localparam int Words = (MAX_BITS + BitsPerWord - 1) / BitsPerWord;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;

  ctrl_state_e state_q, state_d;

  logic [LIM_W-1:0] p_q, p_d;
  logic             val_q, val_d;
  logic             kind_q, kind_d;
  logic [AddrW-1:0] clr_q, clr_d;
  res_t             res_q, res_d;
  logic             out_valid_q;
  res_t             out_q;
  logic             load_out;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [BitsPerWord-1:0] ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  logic [BitsPerWord-1:0] ram_rdata;

  logic [LIM_W-1:0]       in_pos;
  logic                   in_range;
  logic [AddrW-1:0]       p_word;
  logic [LIM_W-1:0]       nbase;
  logic                   nbase_past;
  logic [BitsPerWord-1:0] mask;
  logic [BitsPerWord-1:0] cand;
  logic                   hit;
  logic [OffW-1:0]        hit_k;
  logic [LIM_W-1:0]       pos_k;
  logic                   accept;

  assign in_pos     = LIM_W'(req_i.position);
  assign in_range   = in_pos < limit_i;
  assign p_word     = p_q[AddrW+OffW-1:OffW];
  assign nbase      = (p_q | LIM_W'(BitsPerWord - 1)) + LIM_W'(1);
  assign nbase_past = nbase >= limit_i;
  assign mask       = BitsPerWord'(1) << p_q[OffW-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // match search within the word just read
  always_comb begin
    cand  = '0;
    hit   = 1'b0;
    hit_k = '0;
    pos_k = '0;
    for (int k = 0; k < BitsPerWord; k++) begin
      pos_k   = {p_q[LIM_W-1:OffW], OffW'(k)};
      cand[k] = (ram_rdata[k] == val_q) && (OffW'(k) >= p_q[OffW-1:0])
                && (pos_k < limit_i);
    end
    for (int k = BitsPerWord - 1; k >= 0; k--) begin
      if (cand[k]) begin
        hit   = 1'b1;
        hit_k = OffW'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AddrW'(Words - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (!in_range) state_d = S_FIN;
          else if (req_i.req_type == REQ_SET) state_d = S_SET_WR;
          else state_d = S_CHK;
        end
      end
      S_SET_WR: state_d = S_FIN;
      S_CHK: begin
        if (hit || nbase_past) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_word;
    ram_wdata = val_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_raddr = in_pos[AddrW+OffW-1:OffW];
    p_d       = p_q;
    val_d     = val_q;
    kind_d    = kind_q;
    clr_d     = clr_q;
    res_d     = res_q;
    load_out  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          p_d        = in_pos;
          val_d      = req_i.bit_value;
          kind_d     = req_i.req_type;
          res_d.code = RC_OK;
          res_d.index = '0;
          if (!in_range) begin
            res_d.code = (req_i.req_type == REQ_SET) ? RC_RANGE : RC_NOT_FOUND;
          end
        end
      end
      S_SET_WR: begin
        ram_we = 1'b1;
      end
      S_CHK: begin
        // next word is fetched while this one is checked
        ram_raddr = p_word + 1'b1;
        if (hit) begin
          res_d.code  = RC_OK;
          res_d.index = {p_q[PosW-1:OffW], hit_k};
        end else begin
          p_d = nbase;
          if (nbase_past) begin
            res_d.code  = RC_NOT_FOUND;
            res_d.index = '0;
          end
        end
      end
      S_FIN: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    val_q  <= val_d;
    kind_q <= kind_d;
    res_q  <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  bba_ram #(
    .WIDTH(BitsPerWord),
    .DEPTH(Words),
    .AW   (AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_scan_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> p_q < limit_i)
    else $error("scan pointer past limit");

  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_o.code != RC_OK |-> res_o.index == '0)
    else $error("nonzero index on miss or range error");

  a_range_only_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && res_q.code == RC_RANGE |-> kind_q == REQ_SET)
    else $error("range error on find request");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready right after request");

endmodule

`default_nettype wire

// File: bench/tb_block_bitmap_allocator_core.sv
module tb_block_bitmap_allocator_core;
  import bba_pkg::*;

  localparam int MaxBits    = 4096;
  localparam int CycleLimit = 5000000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CfgW-1:0]     cfg_bits    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                req_type    = REQ_SET;
  logic [PosW-1:0]     position    = '0;
  logic                bit_value   = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [1:0]          result_code;
  logic [PosW-1:0]     found_index;

  // predictor state
  logic [MaxBits-1:0]  occ_map     = '0;
  logic [CfgW-1:0]     limit_q     = 13'd4096;
  res_t                pending_results[$];

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_cycles_req = 0;
  int                  mismatch_cnt   = 0;
  int                  cycle_cnt      = 0;
  bit                  offering       = 1'b0;

  block_bitmap_allocator_core #(
    .MAX_BITS(MaxBits)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_bits_in_use_i(cfg_bits),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .position_i       (position),
    .bit_value_i      (bit_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_code_o    (result_code),
    .found_index_o    (found_index)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic res_t apply_request(input req_t r);
    res_t res;
    int   lim;
    int   p;
    lim = (limit_q > MaxBits) ? MaxBits : int'(limit_q);
    res.code  = RC_OK;
    res.index = '0;
    if (r.req_type == REQ_SET) begin
      if (int'(r.position) >= lim) begin
        res.code = RC_RANGE;
      end else begin
        occ_map[r.position] = r.bit_value;
      end
    end else begin
      res.code = RC_NOT_FOUND;
      for (p = int'(r.position); p < lim; p++) begin
        if (occ_map[p] == r.bit_value) begin
          res.code  = RC_OK;
          res.index = p[PosW-1:0];
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic send_req(input logic kind, input logic [PosW-1:0] pos, input logic val);
    req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    offering  = 1'b1;
    req_type  <= kind;
    position  <= pos;
    bit_value <= val;
    do @(posedge clk_i); while (!in_ready);
    r.req_type  = kind;
    r.position  = pos;
    r.bit_value = val;
    pending_results.push_back(apply_request(r));
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_bits  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    limit_q = v;
    cfg_valid <= 1'b0;
  endtask

  // result checker and receiver stalls
  initial begin : receiver
    int   hold;
    res_t exp_res;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: result_code %0d found_index %0d",
                 result_code, found_index);
          mismatch_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (result_code !== exp_res.code) begin
            $error("result_code: expected %0d, actual %0d", exp_res.code, result_code);
            mismatch_cnt++;
          end
          if (found_index !== exp_res.index) begin
            $error("found_index: expected %0d, actual %0d", exp_res.index, found_index);
            mismatch_cnt++;
          end
        end
      end
      if (hold_cycles_req != 0) begin
        hold = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_cleared_map();
    send_req(REQ_FIND, 12'd0, 1'b0);
    send_req(REQ_FIND, 12'd0, 1'b1);
    send_req(REQ_FIND, 12'd4095, 1'b0);
  endtask

  task automatic test_set_and_find();
    write_limit(13'd4096);
    send_req(REQ_SET, 12'd4095, 1'b1);
    send_req(REQ_FIND, 12'd0, 1'b1);
    send_req(REQ_SET, 12'd0, 1'b1);
    send_req(REQ_SET, 12'd7, 1'b1);
    send_req(REQ_SET, 12'd8, 1'b1);
    send_req(REQ_FIND, 12'd1, 1'b1);
    send_req(REQ_FIND, 12'd0, 1'b0);
    send_req(REQ_SET, 12'd0, 1'b0);
    send_req(REQ_FIND, 12'd0, 1'b1);
    send_req(REQ_SET, 12'd4095, 1'b0);
    send_req(REQ_FIND, 12'd9, 1'b1);
  endtask

  task automatic test_limit_edges();
    // limit just below capacity
    write_limit(13'd4095);
    send_req(REQ_SET, 12'd4095, 1'b1);
    send_req(REQ_FIND, 12'd4095, 1'b0);
    send_req(REQ_FIND, 12'd8, 1'b1);
    // empty map
    write_limit(13'd0);
    send_req(REQ_SET, 12'd0, 1'b1);
    send_req(REQ_FIND, 12'd0, 1'b0);
    write_limit(13'd1);
    send_req(REQ_FIND, 12'd0, 1'b0);
    send_req(REQ_SET, 12'd1, 1'b1);
    // limits above capacity saturate
    write_limit(13'd8191);
    send_req(REQ_SET, 12'd4095, 1'b1);
    send_req(REQ_FIND, 12'haaa, 1'b1);
    write_limit(13'd4097);
    send_req(REQ_FIND, 12'h555, 1'b1);
    send_req(REQ_SET, 12'd4095, 1'b0);
  endtask

  task automatic test_random_mix(input int n, input logic [CfgW-1:0] lim,
                                 input int s_idle, input int r_stall);
    int            eff;
    logic [PosW-1:0] pos;
    write_limit(lim);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    eff = (lim > MaxBits) ? MaxBits : int'(lim);
    repeat (n) begin
      // mostly in-range positions, some anywhere in the field
      if (eff == 0 || $urandom_range(99) < 8) begin
        pos = PosW'($urandom_range(MaxBits - 1));
      end else begin
        pos = PosW'($urandom_range(eff - 1));
      end
      send_req(1'($urandom_range(1)), pos, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_backpressure();
    write_limit(13'd4096);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles_req = 400;
    repeat (30) begin
      send_req(1'($urandom_range(1)), PosW'($urandom_range(MaxBits - 1)),
               1'($urandom_range(1)));
    end
    // sender waits for every outstanding request before going on
    wait_drained();
    repeat (10) begin
      send_req(1'($urandom_range(1)), PosW'($urandom_range(MaxBits - 1)),
               1'($urandom_range(1)));
    end
  endtask

  initial begin : main
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_cleared_map();
    test_set_and_find();
    test_limit_edges();
    test_random_mix(235, 13'd4096, 0, 0);
    test_random_mix(235, 13'd64, 88, 0);
    test_random_mix(235, 13'd8191, 0, 88);
    test_random_mix(235, 13'd1000, 10, 10);
    test_random_mix(235, 13'($urandom_range(8191)), 0, 0);
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
